[hw/rtl/dam_pkg.sv]
// package for the binary64 add / multiply / divide block
// holds field constants, state codes and small decode helpers
// no dependencies
package dam_pkg;

    localparam int unsigned EXP_W   = 13;   // signed working exponent
    localparam int unsigned VAL_W   = 107;  // normalizer / product register
    localparam int unsigned CNT_W   = 7;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_MUL = 2'd1;
    localparam logic [1:0] OP_DIV = 2'd2;

    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] INF_BITS = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] NAN_BITS = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [10:0] EXP_MAX  = 11'h7FF;

    localparam logic signed [EXP_W-1:0] BIAS      = 13'sd1023;
    localparam logic signed [EXP_W-1:0] EMIN      = -13'sd1022;
    localparam logic signed [EXP_W-1:0] MUL_ADJ   = 13'sd52;
    localparam logic signed [EXP_W-1:0] DIV_ADJ   = 13'sd12;

    localparam logic [CNT_W-1:0] MUL_STEPS = 7'd53;
    localparam logic [CNT_W-1:0] DIV_STEPS = 7'd117;

    // sequencer state codes
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DEC   = 4'd1;
    localparam logic [3:0] ST_ADD   = 4'd2;
    localparam logic [3:0] ST_MUL   = 4'd3;
    localparam logic [3:0] ST_DIV   = 4'd4;
    localparam logic [3:0] ST_NRMR  = 4'd5;
    localparam logic [3:0] ST_NRML  = 4'd6;
    localparam logic [3:0] ST_DEN   = 4'd7;
    localparam logic [3:0] ST_PACK  = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    typedef logic signed [EXP_W-1:0] exp_t;

    // significand with hidden bit
    function automatic logic [52:0] mant_of(input logic [63:0] x);
        mant_of = {(x[62:52] != 11'd0), x[51:0]};
    endfunction

    // unbiased exponent, denormals taken as -1022
    function automatic exp_t exp_of(input logic [63:0] x);
        logic [10:0] f;
        f = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
        exp_of = $signed({2'b00, f}) - BIAS;
    endfunction

    function automatic logic is_nan(input logic [63:0] x);
        is_nan = (x[62:52] == EXP_MAX) && (x[51:0] != 52'd0);
    endfunction

    function automatic logic is_inf(input logic [63:0] x);
        is_inf = (x[62:52] == EXP_MAX) && (x[51:0] == 52'd0);
    endfunction

    function automatic logic is_zero(input logic [63:0] x);
        is_zero = (x[62:0] == 63'd0);
    endfunction

endpackage

[hw/rtl/double_add_mul_div.sv]
// flow of an accepted item: decode, then special operands go straight to the done state;
// others pass the add, the 53-step shift-add multiply or the 117-step restoring divide,
// then, as needed, the one-bit normalize and denormal loops and pack; the done state holds
// the result while the previous result still waits in the output register
// throughput: one item at a time, the next item is taken the cycle after the result is queued
// reset: rst_n asynchronous active low returns the sequencer to idle, output empty
module double_add_mul_div
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // operand_a [63:0], operand_b [127:64]
    input  logic [1:0]    s_tuser,   // req_type [1:0]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata    // result_bits [63:0]
);

    logic [3:0]                     state_reg, state_next;
    logic [1:0]                     op_reg, op_next;
    logic [63:0]                    a_reg, a_next;
    logic [63:0]                    b_reg, b_next;
    logic [63:0]                    x_reg, x_next;
    logic [63:0]                    y_reg, y_next;
    logic [dam_pkg::VAL_W-1:0]      v_reg, v_next;
    logic [53:0]                    r_reg, r_next;
    dam_pkg::exp_t                  e_reg, e_next;
    logic                           s_reg, s_next;
    logic [dam_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [63:0]                    res_reg, res_next;
    logic                           ovld_reg, ovld_next;

    assign s_tready = (state_reg == dam_pkg::ST_IDLE);
    assign m_tvalid = ovld_reg;
    assign m_tdata  = res_reg;

    // sequencer and shared datapath
    always_comb
    begin
        logic          na, nb, ia, ib, za, zb, sx;
        logic [63:0]   am, bm, sum, mag;
        dam_pkg::exp_t ea, eb, d;
        logic [5:0]    sh;
        logic [53:0]   psum, r2;
        logic          qb;
        logic [10:0]   bexp;

        state_next = state_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        v_next     = v_reg;
        r_next     = r_reg;
        e_next     = e_reg;
        s_next     = s_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        ovld_next  = ovld_reg;

        na  = dam_pkg::is_nan(a_reg);
        nb  = dam_pkg::is_nan(b_reg);
        ia  = dam_pkg::is_inf(a_reg);
        ib  = dam_pkg::is_inf(b_reg);
        za  = dam_pkg::is_zero(a_reg);
        zb  = dam_pkg::is_zero(b_reg);
        sx  = a_reg[63] ^ b_reg[63];
        ea  = dam_pkg::exp_of(a_reg);
        eb  = dam_pkg::exp_of(b_reg);
        am  = {11'd0, dam_pkg::mant_of(a_reg)};
        bm  = {11'd0, dam_pkg::mant_of(b_reg)};
        if (a_reg[63])
            am = 64'd0 - am;
        if (b_reg[63])
            bm = 64'd0 - bm;
        d   = ea - eb;
        sh  = 6'd0;
        sum = x_reg + y_reg;
        mag = sum[63] ? (64'd0 - sum) : sum;
        psum = v_reg[106:53] + (y_reg[0] ? {1'b0, x_reg[52:0]} : 54'd0);
        r2  = {r_reg[52:0], y_reg[52]};
        qb  = (r2 >= {1'b0, x_reg[52:0]});
        bexp = 11'(e_reg + dam_pkg::BIAS);

        // output register drains independently
        if (ovld_reg && m_tready)
            ovld_next = 1'b0;

        case (state_reg)
            dam_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser;
                    a_next     = s_tdata[63:0];
                    b_next     = s_tdata[127:64];
                    state_next = dam_pkg::ST_DEC;
                end
            end
            dam_pkg::ST_DEC:
            begin
                s_next     = sx;
                v_next     = '0;
                r_next     = '0;
                state_next = dam_pkg::ST_DONE;
                case (op_reg)
                    dam_pkg::OP_ADD:
                    begin
                        if (na || nb)
                            x_next = dam_pkg::NAN_BITS;
                        else if (ia && ib)
                            x_next = sx ? dam_pkg::NAN_BITS : a_reg;
                        else if (ia)
                            x_next = a_reg;
                        else if (ib)
                            x_next = b_reg;
                        else if (za && zb)
                            x_next = (a_reg[63] & b_reg[63]) ? dam_pkg::SIGN_BIT : 64'd0;
                        else
                        begin
                            // align the operand with the smaller exponent
                            if (d > 0)
                            begin
                                sh = (d > 13'sd63) ? 6'd63 : d[5:0];
                                x_next = am;
                                y_next = 64'($signed(bm) >>> sh);
                                e_next = ea;
                            end
                            else
                            begin
                                sh = (-d > 13'sd63) ? 6'd63 : 6'(-d);
                                x_next = 64'($signed(am) >>> sh);
                                y_next = bm;
                                e_next = eb;
                            end
                            state_next = dam_pkg::ST_ADD;
                        end
                    end
                    dam_pkg::OP_MUL:
                    begin
                        if (na || nb)
                            x_next = dam_pkg::NAN_BITS;
                        else if ((ia && zb) || (ib && za))
                            x_next = dam_pkg::NAN_BITS;
                        else if (ia || ib)
                            x_next = {sx, 63'd0} | dam_pkg::INF_BITS;
                        else if (za || zb)
                            x_next = {sx, 63'd0};
                        else
                        begin
                            x_next     = {11'd0, dam_pkg::mant_of(a_reg)};
                            y_next     = {11'd0, dam_pkg::mant_of(b_reg)};
                            e_next     = ea + eb - dam_pkg::MUL_ADJ;
                            cnt_next   = dam_pkg::MUL_STEPS;
                            state_next = dam_pkg::ST_MUL;
                        end
                    end
                    dam_pkg::OP_DIV:
                    begin
                        if (na || nb)
                            x_next = dam_pkg::NAN_BITS;
                        else if (zb)
                            x_next = za ? dam_pkg::NAN_BITS : ({sx, 63'd0} | dam_pkg::INF_BITS);
                        else if (ia)
                            x_next = ib ? dam_pkg::NAN_BITS : ({sx, 63'd0} | dam_pkg::INF_BITS);
                        else if (za || ib)
                            x_next = {sx, 63'd0};
                        else
                        begin
                            x_next     = {11'd0, dam_pkg::mant_of(b_reg)};
                            y_next     = {11'd0, dam_pkg::mant_of(a_reg)};
                            e_next     = ea - eb - dam_pkg::DIV_ADJ;
                            cnt_next   = dam_pkg::DIV_STEPS;
                            state_next = dam_pkg::ST_DIV;
                        end
                    end
                    default:
                        x_next = dam_pkg::NAN_BITS;
                endcase
            end
            dam_pkg::ST_ADD:
            begin
                // signed sum, then sign and magnitude
                s_next = sum[63];
                if (mag == 64'd0)
                begin
                    x_next     = 64'd0;
                    state_next = dam_pkg::ST_DONE;
                end
                else
                begin
                    v_next     = {43'd0, mag};
                    state_next = dam_pkg::ST_NRMR;
                end
            end
            dam_pkg::ST_MUL:
            begin
                // shift-add multiply, one multiplier bit per cycle
                v_next   = {1'b0, psum, v_reg[52:1]};
                y_next   = {1'b0, y_reg[63:1]};
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                    state_next = dam_pkg::ST_NRMR;
            end
            dam_pkg::ST_DIV:
            begin
                // restoring divide, quotient bits gathered into a 53-bit window
                r_next = qb ? (r2 - {1'b0, x_reg[52:0]}) : r2;
                y_next = {y_reg[62:0], 1'b0};
                if (v_reg[52])
                    e_next = e_reg + 13'sd1;
                else
                    v_next = {v_reg[105:0], qb};
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                    state_next = dam_pkg::ST_NRMR;
            end
            dam_pkg::ST_NRMR:
            begin
                if (v_reg[106:53] != 54'd0)
                begin
                    v_next = {1'b0, v_reg[106:1]};
                    e_next = e_reg + 13'sd1;
                end
                else
                    state_next = dam_pkg::ST_NRML;
            end
            dam_pkg::ST_NRML:
            begin
                if (!v_reg[52])
                begin
                    v_next = {v_reg[105:0], 1'b0};
                    e_next = e_reg - 13'sd1;
                end
                else if (e_reg > dam_pkg::BIAS)
                begin
                    x_next     = {s_reg, 63'd0} | dam_pkg::INF_BITS;
                    state_next = dam_pkg::ST_DONE;
                end
                else
                    state_next = dam_pkg::ST_DEN;
            end
            dam_pkg::ST_DEN:
            begin
                // denormal shift until the exponent reaches its floor or the value is zero
                if ((e_reg < dam_pkg::EMIN) && (v_reg != '0))
                begin
                    v_next = {1'b0, v_reg[106:1]};
                    e_next = e_reg + 13'sd1;
                end
                else
                    state_next = dam_pkg::ST_PACK;
            end
            dam_pkg::ST_PACK:
            begin
                x_next     = {s_reg, (v_reg[52] ? bexp : 11'd0), v_reg[51:0]};
                state_next = dam_pkg::ST_DONE;
            end
            dam_pkg::ST_DONE:
            begin
                if (!ovld_reg || m_tready)
                begin
                    res_next   = x_reg;
                    ovld_next  = 1'b1;
                    state_next = dam_pkg::ST_IDLE;
                end
            end
            default:
                state_next = dam_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dam_pkg::ST_IDLE;
            ovld_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ovld_reg  <= ovld_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        v_reg   <= v_next;
        r_reg   <= r_next;
        e_reg   <= e_next;
        s_reg   <= s_next;
        res_reg <= res_next;
    end

    // checks
    a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == dam_pkg::ST_DEC)
        else $error("accepted item did not start decode");

    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dam_pkg::ST_DONE && (!m_tvalid || m_tready) |=> m_tvalid)
        else $error("finished result not queued");

    a_den_norm: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dam_pkg::ST_DEN |-> v_reg[106:53] == 54'd0)
        else $error("denormal stage sees unnormalized value");

    a_iter_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dam_pkg::ST_MUL || state_reg == dam_pkg::ST_DIV |-> cnt_reg != '0)
        else $error("iteration count ran out");

endmodule
